FILE: src/u8u16_pkg.sv
// Shared types, constants and the lead-byte classifier of the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

  // Width of the internal code unit counter; the reported count is 16 bits wide.
  localparam int unsigned CountBits = 16;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned LenW   = 3;
  localparam int unsigned QDepth = 2;

  // Wide enough to compare any counter width against 16-bit values.
  localparam int unsigned CmpW = 33;

  localparam logic [UnitW-1:0] UnsupportedUnit = 16'hFF1F;
  localparam logic [UnitW-1:0] Mask2Lead       = 16'h07C0;
  localparam logic [UnitW-1:0] Mask3Lead       = 16'hF000;
  localparam logic [UnitW-1:0] Mask3Second     = 16'h0FC0;
  localparam logic [UnitW-1:0] MaskLow6        = 16'h003F;
  localparam logic [UnitW-1:0] CountMax        = 16'hFFFF;

  localparam logic [ByteW-1:0] BomByte0 = 8'hEF;
  localparam logic [ByteW-1:0] BomByte1 = 8'hBB;
  localparam logic [ByteW-1:0] BomByte2 = 8'hBF;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusBadLead = 2'd1,
    StatusFull    = 2'd2
  } status_e;

  // One classified byte as it waits between front and back.
  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             in_last;
    logic [LenW-1:0]  len;      // sequence length if this byte is a lead; 0 = invalid lead
  } cls_t;

  // Sequence length implied by a lead byte, 0 for continuation bytes and 0xFE/0xFF.
  function automatic logic [LenW-1:0] lead_length(input logic [ByteW-1:0] b);
    logic [LenW-1:0] len;
    len = 3'd0;
    if (b[7] == 1'b0)            len = 3'd1;
    else if (b[7:6] == 2'b10)    len = 3'd0;
    else if (b[7:5] == 3'b110)   len = 3'd2;
    else if (b[7:4] == 4'b1110)  len = 3'd3;
    else if (b[7:3] == 5'b11110) len = 3'd4;
    else if (b[7:2] == 6'b111110) len = 3'd5;
    else if (b[7:1] == 7'b1111110) len = 3'd6;
    return len;
  endfunction

endpackage

FILE: src/u8u16_if.sv
// Valid/ready channel interfaces for bytes in, results out and the capacity write.
interface u8u16_in_if import u8u16_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface u8u16_out_if import u8u16_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [UnitW-1:0] code_unit;
  logic             unit_valid;
  logic             string_done;
  logic [1:0]       status;
  logic [UnitW-1:0] unit_count;

  modport source (output valid, output code_unit, output unit_valid, output string_done,
                  output status, output unit_count, input ready);
  modport sink   (input valid, input code_unit, input unit_valid, input string_done,
                  input status, input unit_count, output ready);
endinterface

interface u8u16_cfg_if import u8u16_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [UnitW-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

FILE: src/utf8_to_utf16_decoder.sv
// Top level of the streaming UTF-8 to UTF-16 (BMP) decoder.
//
// Bytes enter on byte_i, one request per byte, with in_last on the final byte
// of a string. The block takes one byte per clock cycle while results are
// taken; each byte waits in the front-end queue and its result in the back
// end's output register until it leaves on unit_o. The back end updates the
// decode state (bytes left, lead and second byte, unit count) one byte each
// cycle. A front end classifies each byte's lead length and holds it in a
// two-entry queue, so input and output stall independently; the back end
// keeps its result in an output register and takes the next queued byte in
// the same cycle that result is taken. Each 1-, 2- or 3-byte sequence gives
// one code unit, longer sequences give 0xFF1F, and a leading EF BB BF is
// dropped. An invalid lead byte or a full capacity stops output for the rest
// of the string. A result leaves when a unit is emitted or on the final byte,
// which also reports status and the saturating unit count and clears the
// per-string state. Write capacity through cfg_i only while the block is idle;
// zero means count only, with no units emitted.
module utf8_to_utf16_decoder import u8u16_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  u8u16_cfg_if.sink  cfg_i,
  u8u16_in_if.sink   byte_i,
  u8u16_out_if.source unit_o
);

  logic [UnitW-1:0] capacity_q;
  logic             head_valid;
  logic             head_pop;
  cls_t             head;

  // The capacity register takes a write request in any cycle.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= '0;
    end else if (cfg_i.valid) begin
      capacity_q <= cfg_i.capacity;
    end
  end

  // Classify and queue incoming bytes.
  u8u16_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .head_pop_i   (head_pop)
  );

  // Decode queued bytes and hold results until taken.
  u8u16_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .capacity_i   (capacity_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .unit_o       (unit_o)
  );

endmodule

FILE: src/u8u16_front.sv
// Front end: accept bytes, classify the lead length and hold them in a two-entry queue.
module u8u16_front import u8u16_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  u8u16_in_if.sink       byte_i,
  output logic           head_valid_o,
  output cls_t           head_o,
  input  logic           head_pop_i
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  cls_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;
  cls_t            entry;

  assign byte_i.ready = (count_q != CntW'(QDepth));
  assign push         = byte_i.valid && byte_i.ready;
  assign head_valid_o = (count_q != '0);
  assign pop          = head_pop_i && head_valid_o;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    entry.in_byte = byte_i.in_byte;
    entry.in_last = byte_i.in_last;
    entry.len     = lead_length(byte_i.in_byte);
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

FILE: src/u8u16_back.sv
// Back end: per-string decode state, code unit assembly and the output register.
module u8u16_back import u8u16_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [UnitW-1:0] capacity_i,
  input  logic             head_valid_i,
  input  cls_t             head_i,
  output logic             head_pop_o,
  u8u16_out_if.source      unit_o
);

  logic [LenW-1:0]      bytes_left_q, bytes_left_d;
  logic [LenW-1:0]      seq_length_q, seq_length_d;
  logic [ByteW-1:0]     lead_byte_q, lead_byte_d;
  logic [ByteW-1:0]     second_byte_q, second_byte_d;
  logic [CountBits-1:0] units_seen_q, units_seen_d;
  status_e              stop_code_q, stop_code_d;
  logic                 at_start_q, at_start_d;

  logic             out_valid_q, out_valid_d;
  logic [UnitW-1:0] code_unit_q, code_unit_d;
  logic             unit_valid_q, unit_valid_d;
  logic             string_done_q, string_done_d;
  status_e          status_q, status_d;
  logic [UnitW-1:0] unit_count_q, unit_count_d;

  logic             adv, complete, emit, bom, cap_hit;
  logic [ByteW-1:0] third;
  logic [LenW-1:0]  pos;
  logic [UnitW-1:0] unit;

  function automatic logic [UnitW-1:0] decode_unit(input logic [LenW-1:0]  seq,
                                                  input logic [ByteW-1:0] lead,
                                                  input logic [ByteW-1:0] second,
                                                  input logic [ByteW-1:0] thrd);
    logic [UnitW-1:0] u;
    unique case (seq)
      3'd1:    u = {8'd0, lead};
      3'd2:    u = (({8'd0, lead} << 6) & Mask2Lead) | ({8'd0, second} & MaskLow6);
      3'd3:    u = (({8'd0, lead} << 12) & Mask3Lead) | (({8'd0, second} << 6) & Mask3Second)
                   | ({8'd0, thrd} & MaskLow6);
      default: u = UnsupportedUnit;
    endcase
    return u;
  endfunction

  // Advance one queued byte whenever the output register is free or being drained.
  assign adv        = head_valid_i && (!out_valid_q || unit_o.ready);
  assign head_pop_o = adv;
  assign cap_hit    = (capacity_i != '0) && (CmpW'(units_seen_q) >= CmpW'(capacity_i));
  assign pos        = seq_length_q - bytes_left_q;

  always_comb begin
    bytes_left_d  = bytes_left_q;
    seq_length_d  = seq_length_q;
    lead_byte_d   = lead_byte_q;
    second_byte_d = second_byte_q;
    units_seen_d  = units_seen_q;
    stop_code_d   = stop_code_q;
    at_start_d    = at_start_q;
    complete      = 1'b0;
    third         = '0;
    emit          = 1'b0;
    bom           = 1'b0;
    unit          = '0;

    if (stop_code_q == StatusOk) begin
      if (bytes_left_q == '0) begin
        if (head_i.len == '0) begin
          stop_code_d = StatusBadLead;
        end else if (cap_hit) begin
          stop_code_d = StatusFull;
        end else begin
          lead_byte_d   = head_i.in_byte;
          second_byte_d = '0;
          seq_length_d  = head_i.len;
          bytes_left_d  = head_i.len - LenW'(1);
          complete      = (head_i.len == LenW'(1)) || head_i.in_last;
        end
      end else begin
        if (pos == LenW'(1)) begin
          second_byte_d = head_i.in_byte;
        end else if (pos == LenW'(2)) begin
          third = head_i.in_byte;
        end
        bytes_left_d = bytes_left_q - LenW'(1);
        complete     = (bytes_left_q == LenW'(1)) || head_i.in_last;
      end
    end

    if (complete) begin
      // Drop a byte-order mark only as the first sequence of a string.
      bom = at_start_q && (seq_length_d == LenW'(3)) && (lead_byte_d == BomByte0)
            && (second_byte_d == BomByte1) && (third == BomByte2);
      at_start_d   = 1'b0;
      bytes_left_d = '0;
      if (!bom) begin
        if (units_seen_q != '1) begin
          units_seen_d = units_seen_q + CountBits'(1);
        end
        if (capacity_i != '0) begin
          unit = decode_unit(seq_length_d, lead_byte_d, second_byte_d, third);
          emit = 1'b1;
        end
      end
    end

    code_unit_d   = emit ? unit : '0;
    unit_valid_d  = emit;
    string_done_d = head_i.in_last;
    status_d      = stop_code_d;
    unit_count_d  = (CmpW'(units_seen_d) > CmpW'(CountMax)) ? CountMax : UnitW'(units_seen_d);

    if (head_i.in_last) begin
      bytes_left_d  = '0;
      seq_length_d  = '0;
      lead_byte_d   = '0;
      second_byte_d = '0;
      units_seen_d  = '0;
      stop_code_d   = StatusOk;
      at_start_d    = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = emit || head_i.in_last;
    end else if (unit_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q  <= '0;
      seq_length_q  <= '0;
      lead_byte_q   <= '0;
      second_byte_q <= '0;
      units_seen_q  <= '0;
      stop_code_q   <= StatusOk;
      at_start_q    <= 1'b1;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (adv) begin
        bytes_left_q  <= bytes_left_d;
        seq_length_q  <= seq_length_d;
        lead_byte_q   <= lead_byte_d;
        second_byte_q <= second_byte_d;
        units_seen_q  <= units_seen_d;
        stop_code_q   <= stop_code_d;
        at_start_q    <= at_start_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      code_unit_q   <= code_unit_d;
      unit_valid_q  <= unit_valid_d;
      string_done_q <= string_done_d;
      status_q      <= status_d;
      unit_count_q  <= unit_count_d;
    end
  end

  assign unit_o.valid       = out_valid_q;
  assign unit_o.code_unit   = code_unit_q;
  assign unit_o.unit_valid  = unit_valid_q;
  assign unit_o.string_done = string_done_q;
  assign unit_o.status      = status_q;
  assign unit_o.unit_count  = unit_count_q;

endmodule

FILE: verif/utf8_to_utf16_decoder_tb.sv
// Self-checking testbench of the UTF-8 to UTF-16 decoder: directed strings, random strings, stalls.
module utf8_to_utf16_decoder_tb;
  import u8u16_pkg::*;

  // Generous cycle budget; a clean run ends well before it.
  localparam int unsigned CycleLimit = 100000;
  // Cycles to wait after the last expected result, so that bytes with no result drain.
  localparam int unsigned TailCycles = 8;
  // Bytes that the decoder actually consumes per random group.
  localparam int unsigned GroupBytes = 100;
  // The internal counter saturates at CountBits ones.
  localparam longint unsigned CountLimit = (64'd1 << CountBits) - 1;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             unit_valid;
    logic             string_done;
    status_e          status;
    logic [UnitW-1:0] unit_count;
  } unit_rec_t;

  logic clk;
  logic rst_n;

  u8u16_cfg_if cfg_bus ();
  u8u16_in_if  byte_bus ();
  u8u16_out_if unit_bus ();

  utf8_to_utf16_decoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .byte_i (byte_bus),
    .unit_o (unit_bus)
  );

  // Decoder state as the testbench predicts it.
  logic [UnitW-1:0] capacity_q;
  logic [LenW-1:0]  left_q;
  logic [LenW-1:0]  len_q;
  logic [ByteW-1:0] lead_q;
  logic [ByteW-1:0] second_q;
  longint unsigned  units_q;
  status_e          stop_q;
  logic             fresh_q;

  unit_rec_t        expected_units[$];
  unit_rec_t        oldest_unit;
  logic [ByteW-1:0] pending_str[$];

  int err_count     = 0;
  int cycle_count   = 0;
  int live_bytes    = 0;  // bytes consumed while the string was still running
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;  // cycles the receiver still holds off

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Sequence length announced by a lead byte; zero for continuation bytes, 0xFE and 0xFF.
  function automatic logic [LenW-1:0] seq_len_of(input logic [ByteW-1:0] b);
    casez (b)
      8'b0???????: return 3'd1;
      8'b110?????: return 3'd2;
      8'b1110????: return 3'd3;
      8'b11110???: return 3'd4;
      8'b111110??: return 3'd5;
      8'b1111110?: return 3'd6;
      default:     return 3'd0;
    endcase
  endfunction

  // Assemble the code unit from the held lead and second byte and the current third byte.
  function automatic logic [UnitW-1:0] assemble_unit(input logic [ByteW-1:0] third);
    case (len_q)
      3'd1:    return {8'h00, lead_q};
      3'd2:    return {5'h00, lead_q[4:0], second_q[5:0]};
      3'd3:    return {lead_q[3:0], second_q[5:0], third[5:0]};
      default: return UnsupportedUnit;
    endcase
  endfunction

  task automatic clear_string_state();
    left_q   = '0;
    len_q    = '0;
    lead_q   = '0;
    second_q = '0;
    units_q  = 0;
    stop_q   = StatusOk;
    fresh_q  = 1'b1;
  endtask

  // Advance the predicted state by one accepted byte and queue the result it causes, if any.
  task automatic decode_byte(input logic [ByteW-1:0] b, input logic last);
    logic             seq_done;
    logic             emit;
    logic             bom;
    logic [ByteW-1:0] third;
    logic [LenW-1:0]  n;
    logic [LenW-1:0]  pos;
    unit_rec_t        r;
    seq_done = 1'b0;
    emit     = 1'b0;
    third    = '0;
    r        = '0;
    if (stop_q == StatusOk) begin
      live_bytes++;
      if (left_q == 0) begin
        n = seq_len_of(b);
        if (n == 0) begin
          stop_q = StatusBadLead;
        end else if (capacity_q != 0 && units_q >= capacity_q) begin
          stop_q = StatusFull;
        end else begin
          lead_q   = b;
          second_q = '0;
          len_q    = n;
          left_q   = n - 3'd1;
          seq_done = (left_q == 0) || last;
        end
      end else begin
        // Continuation bytes are taken unchecked; only the second and third carry bits.
        pos = len_q - left_q;
        if (pos == 3'd1) second_q = b;
        else if (pos == 3'd2) third = b;
        left_q   = left_q - 3'd1;
        seq_done = (left_q == 0) || last;
      end
    end
    if (seq_done) begin
      // A truncated sequence reaches here with its missing bytes left at zero.
      bom = fresh_q && len_q == 3'd3 && lead_q == BomByte0 && second_q == BomByte1 &&
            third == BomByte2;
      fresh_q = 1'b0;
      left_q  = '0;
      if (!bom) begin
        if (units_q < CountLimit) units_q++;
        if (capacity_q != 0) begin
          r.code_unit  = assemble_unit(third);
          r.unit_valid = 1'b1;
          emit         = 1'b1;
        end
      end
    end
    if (emit || last) begin
      r.string_done = last;
      r.status      = stop_q;
      r.unit_count  = (units_q > CountMax) ? CountMax : UnitW'(units_q);
      expected_units.push_back(r);
    end
    if (last) clear_string_state();
  endtask

  // Follow every accepted request on the configuration and byte channels.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      capacity_q = '0;
      clear_string_state();
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) capacity_q = cfg_bus.capacity;
      if (byte_bus.valid && byte_bus.ready) decode_byte(byte_bus.in_byte, byte_bus.in_last);
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got %0h, want %0h (cycle %0d)", field, got, want, cycle_count);
    err_count++;
  endtask

  // Compare each accepted result with the oldest prediction, field by field.
  always @(posedge clk) begin
    if (rst_n && unit_bus.valid && unit_bus.ready) begin
      if (expected_units.size() == 0) begin
        report_mismatch("result with none expected, unit", 32'(unit_bus.code_unit), 0);
      end else begin
        oldest_unit = expected_units.pop_front();
        if (unit_bus.code_unit !== oldest_unit.code_unit)
          report_mismatch("code_unit", 32'(unit_bus.code_unit), 32'(oldest_unit.code_unit));
        if (unit_bus.unit_valid !== oldest_unit.unit_valid)
          report_mismatch("unit_valid", 32'(unit_bus.unit_valid),
                          32'(oldest_unit.unit_valid));
        if (unit_bus.string_done !== oldest_unit.string_done)
          report_mismatch("string_done", 32'(unit_bus.string_done),
                          32'(oldest_unit.string_done));
        if (unit_bus.status !== oldest_unit.status)
          report_mismatch("status", 32'(unit_bus.status), 32'(oldest_unit.status));
        if (unit_bus.unit_count !== oldest_unit.unit_count)
          report_mismatch("unit_count", 32'(unit_bus.unit_count),
                          32'(oldest_unit.unit_count));
      end
    end
  end

  // Stop a hung run.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin
    unit_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        unit_bus.ready <= 1'b0;
      end else begin
        unit_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks; each starts and ends at a falling edge
  // ---------------------------------------------------------------------------

  // Offer one byte request, after a random gap, and hold it until it is taken.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_bus.valid <= 1'b0;
      @(negedge clk);
    end
    byte_bus.valid   <= 1'b1;
    byte_bus.in_byte <= b;
    byte_bus.in_last <= last;
    do @(posedge clk); while (!byte_bus.ready);
    @(negedge clk);
  endtask

  task automatic send_pending_string();
    foreach (pending_str[i]) send_byte(pending_str[i], i == pending_str.size() - 1);
  endtask

  // Drop valid, wait out every predicted result, then let bytes with no result drain too.
  task automatic wait_results_done();
    byte_bus.valid <= 1'b0;
    while (expected_units.size() != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);
  endtask

  // Write the capacity register, only once the block is idle.
  task automatic write_capacity(input logic [UnitW-1:0] value);
    wait_results_done();
    cfg_bus.valid    <= 1'b1;
    cfg_bus.capacity <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // One-, two-, three- and four-byte forms in one string, then a full six-byte form.
  task automatic test_sequence_forms();
    write_capacity(16'hFFFF);
    pending_str = '{8'h00, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
                    8'h7F};
    send_pending_string();
    pending_str = '{8'hFC, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
    send_pending_string();
  endtask

  // A leading byte-order mark gives neither a unit nor a count.
  task automatic test_byte_order_mark();
    pending_str = '{BomByte0, BomByte1, BomByte2, 8'h41};
    send_pending_string();
  endtask

  // Continuation byte as lead, then 0xFE and 0xFF as whole strings.
  task automatic test_bad_lead();
    pending_str = '{8'h80, 8'h41};
    send_pending_string();
    pending_str = '{8'hFE};
    send_pending_string();
    pending_str = '{8'hFF};
    send_pending_string();
  endtask

  // A three-byte form cut short by the final byte.
  task automatic test_truncated_sequence();
    pending_str = '{8'hE2, 8'h82};
    send_pending_string();
  endtask

  // Capacity of one: the second lead byte stops the string.
  task automatic test_capacity_limit();
    write_capacity(16'h0001);
    pending_str = '{8'h41, 8'h42};
    send_pending_string();
  endtask

  // Capacity of zero: count only, one result on the final byte.
  task automatic test_count_only();
    write_capacity(16'h0000);
    pending_str = '{8'h41, 8'h42};
    send_pending_string();
  endtask

  // ---------------------------------------------------------------------------
  // Random strings
  // ---------------------------------------------------------------------------

  // Mostly well-formed sequences with random content; some noise, bad leads and cut ends.
  task automatic build_random_string();
    int kind;
    int len;
    int cut;
    int pick;
    pending_str.delete();
    if ($urandom_range(9) == 0) begin
      pending_str.push_back(BomByte0);
      pending_str.push_back(BomByte1);
      // Spoil the mark now and then so that a near miss decodes as a plain unit.
      pending_str.push_back(($urandom_range(3) == 0) ? ByteW'($urandom) : BomByte2);
    end
    repeat ($urandom_range(1, 8)) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        pending_str.push_back(ByteW'($urandom_range(127)));
      end else if (kind < 85) begin
        if (kind < 55) len = 2;
        else if (kind < 75) len = 3;
        else len = $urandom_range(4, 6);
        case (len)
          2:       pending_str.push_back({3'b110, 5'($urandom)});
          3:       pending_str.push_back({4'b1110, 4'($urandom)});
          4:       pending_str.push_back({5'b11110, 3'($urandom)});
          5:       pending_str.push_back({6'b111110, 2'($urandom)});
          default: pending_str.push_back({7'b1111110, 1'($urandom)});
        endcase
        // Continuation bytes are not checked, so let some of them be anything.
        repeat (len - 1) begin
          if ($urandom_range(9) == 0) pending_str.push_back(ByteW'($urandom));
          else pending_str.push_back({2'b10, 6'($urandom)});
        end
      end else if (kind < 93) begin
        pending_str.push_back(ByteW'($urandom));
      end else begin
        pick = $urandom_range(3);
        if (pick == 0) pending_str.push_back(8'hFE);
        else if (pick == 1) pending_str.push_back(8'hFF);
        else pending_str.push_back({2'b10, 6'($urandom)});
      end
    end
    if ($urandom_range(99) < 15 && pending_str.size() > 1) begin
      cut = $urandom_range(1, (pending_str.size() > 2) ? 2 : 1);
      repeat (cut) void'(pending_str.pop_back());
    end
  endtask

  // Three capacity groups per phase: count only, a tiny limit, a random limit.
  task automatic run_random_phase(input int send_pct, input int recv_pct);
    int start;
    int strings;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int g = 0; g < 3; g++) begin
      case (g)
        0:       write_capacity(16'h0000);
        1:       write_capacity(UnitW'($urandom_range(1, 6)));
        default: write_capacity(UnitW'($urandom_range(7, 65535)));
      endcase
      start   = live_bytes;
      strings = 0;
      // With a zero capacity only final bytes answer, so go on until enough strings ended.
      while ((live_bytes - start) < GroupBytes || (g == 0 && strings < 20)) begin
        build_random_string();
        send_pending_string();
        strings++;
        if ($urandom_range(99) < 4) wait_results_done();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Pressure
  // ---------------------------------------------------------------------------

  // Hold the receiver off while bytes keep coming, so the block fills and stalls its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(16'hFFFF);
    hold_left = 64;
    for (int i = 0; i < 40; i++) send_byte(8'h30 + ByteW'(i % 10), i == 39);
    wait_results_done();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------

  initial begin
    rst_n            = 1'b0;
    byte_bus.valid   = 1'b0;
    byte_bus.in_byte = '0;
    byte_bus.in_last = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.capacity = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_idle_pct = 13;
    recv_idle_pct = 65;
    test_sequence_forms();
    test_byte_order_mark();
    test_bad_lead();
    test_truncated_sequence();
    test_capacity_limit();
    test_count_only();

    run_random_phase(13, 65);
    run_random_phase(65, 13);
    run_random_phase(0, 0);

    test_backpressure();

    wait_results_done();
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/u8u16_pkg.sv
src/u8u16_if.sv
src/u8u16_front.sv
src/u8u16_back.sv
src/utf8_to_utf16_decoder.sv
verif/utf8_to_utf16_decoder_tb.sv
